/* sv/slfr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the sync/length frame receiver.
package slfr_pkg;

   localparam int unsigned SLFR_SLOT_COUNT      = 3;
   localparam int unsigned SLFR_MAX_FRAME_BYTES = 131072;

   localparam logic [17:0] MAX_LEN_RESET = 18'd131072;

   localparam logic [7:0] SYNC_BYTE_0 = 8'hAA;
   localparam logic [7:0] SYNC_BYTE_1 = 8'hBB;
   localparam logic [7:0] SYNC_BYTE_2 = 8'hCC;
   localparam logic [7:0] SYNC_BYTE_3 = 8'hDD;

   typedef enum logic [2:0] {
      REQ_BYTE    = 3'd0,
      REQ_ACQUIRE = 3'd1,
      REQ_RELEASE = 3'd2,
      REQ_READ    = 3'd3,
      REQ_ABORT   = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      STS_NOTHING   = 3'd0,
      STS_PUBLISHED = 3'd1,
      STS_BAD_LEN   = 3'd2,
      STS_DROPPING  = 3'd3,
      STS_ABORTED   = 3'd4,
      STS_GRANTED   = 3'd5,
      STS_NONE_RDY  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      PH_SYNC    = 2'd0,
      PH_LEN     = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_DROP    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_FREE      = 2'd0,
      ST_RECEIVING = 2'd1,
      ST_READY     = 2'd2,
      ST_READING   = 2'd3
   } slot_state_type;

   typedef struct packed {
      status_type  status;
      logic [1:0]  slot_index;
      logic [17:0] frame_len;
      logic [31:0] frame_seq;
      logic        read_ok;
   } result_type;

   function automatic logic [7:0] sync_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0:    b = SYNC_BYTE_0;
         2'd1:    b = SYNC_BYTE_1;
         2'd2:    b = SYNC_BYTE_2;
         default: b = SYNC_BYTE_3;
      endcase
      return b;
   endfunction

endpackage

/* sv/sync_length_frame_receiver_triple_buffer_top.sv */
`timescale 1ns / 1ps
// Top level of the sync/length frame receiver with slot buffer.
//
//   channel  direction  transfer when            payload
//   req      in         req_valid & req_ready    req_type, req_rx_byte, req_read_slot,
//                                                req_read_offset
//   rsp      out        rsp_valid & rsp_ready    rsp_status, rsp_slot_index, rsp_frame_len,
//                                                rsp_frame_seq, rsp_read_data
//   csr      in         csr_write_enable         csr_write_data (max frame length)
//
// One request per cycle while req_ready is high; results pass stage_ff, then rsp_ff.
// The single-port payload RAM is written by payload bytes and read by read requests,
// at most one access per request, so the rate is set by that port: one request per cycle.
// Reset clears the receiver and slot table; payload RAM holds no reset value.
// A stalled response holds in the output register while one more request is
// taken into the RAM read stage; req_ready drops only when both are full.
module sync_length_frame_receiver_triple_buffer_top import slfr_pkg::*; #(
   parameter int unsigned SLOT_COUNT      = SLFR_SLOT_COUNT,
   parameter int unsigned MAX_FRAME_BYTES = SLFR_MAX_FRAME_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [17:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_rx_byte,
   input  logic [1:0]  req_read_slot,
   input  logic [16:0] req_read_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_slot_index,
   output logic [17:0] rsp_frame_len,
   output logic [31:0] rsp_frame_seq,
   output logic [7:0]  rsp_read_data
);

   localparam int unsigned AW = $clog2(SLOT_COUNT * MAX_FRAME_BYTES);

   logic          step;
   logic          advance;
   result_type    result;
   logic          mem_we;
   logic          mem_re;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata;
   logic [7:0]    mem_rdata;

   logic          stage_valid_ff, stage_valid_in;
   result_type    stage_ff;
   logic          rsp_valid_ff,   rsp_valid_in;
   result_type    rsp_ff;
   logic [7:0]    rsp_data_ff;

   slfr_engine #(
      .SLOT_COUNT      (SLOT_COUNT),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (step),
      .req_type         (req_type),
      .req_rx_byte      (req_rx_byte),
      .req_read_slot    (req_read_slot),
      .req_read_offset  (req_read_offset),
      .result           (result),
      .mem_we           (mem_we),
      .mem_re           (mem_re),
      .mem_addr         (mem_addr),
      .mem_wdata        (mem_wdata)
   );

   slfr_ram #(
      .WIDTH (8),
      .DEPTH (SLOT_COUNT * MAX_FRAME_BYTES)
   ) u_payload_ram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign step      = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (step) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         stage_ff <= result;
      end
      if (advance) begin
         rsp_ff      <= stage_ff;
         rsp_data_ff <= stage_ff.read_ok ? mem_rdata : 8'd0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_slot_index = rsp_ff.slot_index;
   assign rsp_frame_len  = rsp_ff.frame_len;
   assign rsp_frame_seq  = rsp_ff.frame_seq;
   assign rsp_read_data  = rsp_data_ff;

endmodule

/* sv/slfr_ram.sv */
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
module slfr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/slfr_engine.sv */
`timescale 1ns / 1ps
// Receiver phase machine, slot table and frame counter; one transfer per cycle while step is high.
module slfr_engine import slfr_pkg::*; #(
   parameter int unsigned SLOT_COUNT      = SLFR_SLOT_COUNT,
   parameter int unsigned MAX_FRAME_BYTES = SLFR_MAX_FRAME_BYTES,
   localparam int unsigned AW = $clog2(SLOT_COUNT * MAX_FRAME_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [17:0]       csr_write_data,
   input  logic              step,
   input  logic [2:0]        req_type,
   input  logic [7:0]        req_rx_byte,
   input  logic [1:0]        req_read_slot,
   input  logic [16:0]       req_read_offset,
   output result_type        result,
   output logic              mem_we,
   output logic              mem_re,
   output logic [AW-1:0]     mem_addr,
   output logic [7:0]        mem_wdata
);

   localparam int unsigned SW = $clog2(SLOT_COUNT);
   localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);

   logic [17:0]    max_len_ff,     max_len_in;
   phase_type      phase_ff,       phase_in;
   logic [1:0]     sync_count_ff,  sync_count_in;
   logic [1:0]     len_count_ff,   len_count_in;
   logic [31:0]    len_accum_ff,   len_accum_in;
   logic [CW-1:0]  pay_count_ff,   pay_count_in;
   logic [SW-1:0]  target_ff,      target_in;
   slot_state_type slot_state_ff [SLOT_COUNT];
   slot_state_type slot_state_in [SLOT_COUNT];
   logic [17:0]    slot_size_ff   [SLOT_COUNT];
   logic [17:0]    slot_size_in   [SLOT_COUNT];
   logic [31:0]    slot_num_ff    [SLOT_COUNT];
   logic [31:0]    slot_num_in    [SLOT_COUNT];
   logic [31:0]    frame_count_ff, frame_count_in;

   logic              free_found;
   logic [SW-1:0]     free_idx;
   logic              rdy_found;
   logic [SW-1:0]     rdy_idx;
   logic              rdg_found;
   logic [SW-1:0]     rdg_idx;
   logic [31:0]       accum_next;
   logic [CW-1:0]     count_next;
   logic [SLOT_COUNT-1:0] ready_vec;
   logic [SLOT_COUNT-1:0] recv_vec;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      rdg_found  = 1'b0;
      rdg_idx    = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (slot_state_ff[i] == ST_FREE) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
         if (slot_state_ff[i] == ST_READING) begin
            rdg_found = 1'b1;
            rdg_idx   = SW'(i);
         end
      end
      rdy_found = 1'b0;
      rdy_idx   = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slot_state_ff[i] == ST_READY &&
             (!rdy_found || slot_num_ff[i] > slot_num_ff[rdy_idx])) begin
            rdy_found = 1'b1;
            rdy_idx   = SW'(i);
         end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         ready_vec[i] = (slot_state_ff[i] == ST_READY);
         recv_vec[i]  = (slot_state_ff[i] == ST_RECEIVING);
      end
   end

   assign accum_next = len_accum_ff | (32'(req_rx_byte) << {len_count_ff, 3'b000});
   assign count_next = pay_count_ff + 1'b1;

   always_comb begin
      max_len_in     = csr_write_enable ? csr_write_data : max_len_ff;
      phase_in       = phase_ff;
      sync_count_in  = sync_count_ff;
      len_count_in   = len_count_ff;
      len_accum_in   = len_accum_ff;
      pay_count_in   = pay_count_ff;
      target_in      = target_ff;
      slot_state_in  = slot_state_ff;
      slot_size_in   = slot_size_ff;
      slot_num_in    = slot_num_ff;
      frame_count_in = frame_count_ff;
      result         = '0;
      result.status  = STS_NOTHING;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_addr       = AW'(AW'(target_ff) * AW'(MAX_FRAME_BYTES) + AW'(pay_count_ff));
      mem_wdata      = req_rx_byte;
      if (step) begin
         unique case (req_type)
            REQ_BYTE: begin
               unique case (phase_ff)
                  PH_SYNC: begin
                     if (req_rx_byte == sync_byte(sync_count_ff)) begin
                        if (sync_count_ff == 2'd3) begin
                           phase_in      = PH_LEN;
                           sync_count_in = '0;
                           len_count_in  = '0;
                           len_accum_in  = '0;
                        end else begin
                           sync_count_in = sync_count_ff + 2'd1;
                        end
                     end else begin
                        sync_count_in = (req_rx_byte == SYNC_BYTE_0) ? 2'd1 : 2'd0;
                     end
                  end
                  PH_LEN: begin
                     len_accum_in = accum_next;
                     if (len_count_ff != 2'd3) begin
                        len_count_in = len_count_ff + 2'd1;
                     end else begin
                        len_count_in = '0;
                        if (accum_next == 32'd0 || accum_next > 32'(max_len_ff) ||
                            accum_next > 32'(MAX_FRAME_BYTES)) begin
                           phase_in      = PH_SYNC;
                           len_accum_in  = '0;
                           pay_count_in  = '0;
                           result.status = STS_BAD_LEN;
                        end else begin
                           pay_count_in = '0;
                           if (free_found) begin
                              slot_state_in[free_idx] = ST_RECEIVING;
                              target_in               = free_idx;
                              phase_in                = PH_PAYLOAD;
                           end else begin
                              phase_in      = PH_DROP;
                              result.status = STS_DROPPING;
                           end
                        end
                     end
                  end
                  PH_DROP: begin
                     pay_count_in  = count_next;
                     result.status = STS_DROPPING;
                     if (32'(count_next) >= len_accum_ff) begin
                        phase_in     = PH_SYNC;
                        len_accum_in = '0;
                        pay_count_in = '0;
                     end
                  end
                  default: begin
                     mem_we       = 1'b1;
                     pay_count_in = count_next;
                     if (32'(count_next) >= len_accum_ff) begin
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                           if (i != int'(target_ff) && slot_state_ff[i] == ST_READY) begin
                              slot_state_in[i] = ST_FREE;
                              slot_size_in[i]  = '0;
                           end
                        end
                        slot_size_in[target_ff]  = 18'(len_accum_ff);
                        slot_num_in[target_ff]   = frame_count_ff + 32'd1;
                        slot_state_in[target_ff] = ST_READY;
                        frame_count_in           = frame_count_ff + 32'd1;
                        phase_in                 = PH_SYNC;
                        len_accum_in             = '0;
                        pay_count_in             = '0;
                        result.status            = STS_PUBLISHED;
                        result.slot_index        = 2'(target_ff);
                        result.frame_len         = 18'(len_accum_ff);
                        result.frame_seq         = frame_count_ff + 32'd1;
                     end
                  end
               endcase
            end
            REQ_ACQUIRE: begin
               if (rdy_found) begin
                  slot_state_in[rdy_idx] = ST_READING;
                  result.status          = STS_GRANTED;
                  result.slot_index      = 2'(rdy_idx);
                  result.frame_len       = slot_size_ff[rdy_idx];
                  result.frame_seq       = slot_num_ff[rdy_idx];
               end else begin
                  result.status = STS_NONE_RDY;
               end
            end
            REQ_RELEASE: begin
               if (rdg_found) begin
                  slot_state_in[rdg_idx] = ST_FREE;
                  slot_size_in[rdg_idx]  = '0;
               end
            end
            REQ_READ: begin
               mem_re   = 1'b1;
               mem_addr = AW'(AW'(req_read_slot) * AW'(MAX_FRAME_BYTES) +
                              AW'(req_read_offset));
               result.read_ok = (32'(req_read_slot) < 32'(SLOT_COUNT)) &&
                                (32'(req_read_offset) < 32'(MAX_FRAME_BYTES));
            end
            REQ_ABORT: begin
               if (phase_ff != PH_SYNC) begin
                  if (phase_ff == PH_PAYLOAD && slot_state_ff[target_ff] == ST_RECEIVING) begin
                     slot_state_in[target_ff] = ST_FREE;
                  end
                  phase_in      = PH_SYNC;
                  sync_count_in = '0;
                  len_count_in  = '0;
                  len_accum_in  = '0;
                  pay_count_in  = '0;
                  result.status = STS_ABORTED;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff     <= MAX_LEN_RESET;
         phase_ff       <= PH_SYNC;
         sync_count_ff  <= '0;
         len_count_ff   <= '0;
         len_accum_ff   <= '0;
         pay_count_ff   <= '0;
         target_ff      <= '0;
         frame_count_ff <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_state_ff[i] <= ST_FREE;
            slot_size_ff[i]  <= '0;
            slot_num_ff[i]   <= '0;
         end
      end else begin
         max_len_ff     <= max_len_in;
         phase_ff       <= phase_in;
         sync_count_ff  <= sync_count_in;
         len_count_ff   <= len_count_in;
         len_accum_ff   <= len_accum_in;
         pay_count_ff   <= pay_count_in;
         target_ff      <= target_in;
         frame_count_ff <= frame_count_in;
         slot_state_ff  <= slot_state_in;
         slot_size_ff   <= slot_size_in;
         slot_num_ff    <= slot_num_in;
      end
   end

   a_one_receiving: assert property (@(posedge clock) disable iff (reset)
      $countones(recv_vec) <= 1)
      else $error("more than one slot receiving");

   a_one_ready: assert property (@(posedge clock) disable iff (reset)
      $countones(ready_vec) <= 1)
      else $error("more than one slot ready");

   a_target_receiving: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> slot_state_ff[target_ff] == ST_RECEIVING)
      else $error("payload phase without a receiving slot");

   a_publish_count: assert property (@(posedge clock) disable iff (reset)
      step && result.status == STS_PUBLISHED |=>
         frame_count_ff == $past(frame_count_ff) + 32'd1)
      else $error("frame counter did not advance on publish");

endmodule

/* tb/sv/slfr_frame_scoreboard.sv */
`timescale 1ns / 1ps
// Scoreboard for the frame receiver: follows both channels, predicts each response, compares.
module slfr_frame_scoreboard import slfr_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [17:0]                      csr_write_data,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [2:0]                       req_type,
   input  logic [7:0]                       req_rx_byte,
   input  logic [1:0]                       req_read_slot,
   input  logic [16:0]                      req_read_offset,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [2:0]                       rsp_status,
   input  logic [1:0]                       rsp_slot_index,
   input  logic [17:0]                      rsp_frame_len,
   input  logic [31:0]                      rsp_frame_seq,
   input  logic [7:0]                       rsp_read_data,
   output int unsigned                      error_count,
   output int unsigned                      pending_count,
   output int unsigned                      responses_checked,
   output int unsigned                      frames_published,
   output logic [SLFR_SLOT_COUNT-1:0][17:0] written_extent
);

   typedef struct packed {
      status_type  status;
      logic [1:0]  slot_index;
      logic [17:0] frame_len;
      logic [31:0] frame_seq;
      logic [7:0]  read_data;
   } frame_response_type;

   localparam logic [3:0][7:0] SYNC_WORD = {SYNC_BYTE_3, SYNC_BYTE_2, SYNC_BYTE_1, SYNC_BYTE_0};

   logic [17:0]                      max_len;
   phase_type                        phase;
   logic [1:0]                       sync_matched;
   logic [1:0]                       len_bytes;
   logic [31:0]                      len_value;
   logic [17:0]                      bytes_taken;
   logic [1:0]                       fill_slot;
   slot_state_type                   slot_mode [SLFR_SLOT_COUNT];
   logic [17:0]                      slot_len  [SLFR_SLOT_COUNT];
   logic [31:0]                      slot_seq  [SLFR_SLOT_COUNT];
   logic [31:0]                      seq_counter;
   logic [7:0]                       frame_bytes [int unsigned];
   logic [SLFR_SLOT_COUNT-1:0][17:0] extent;
   frame_response_type               awaited [$];

   function automatic void restart_search();
      phase        = PH_SYNC;
      sync_matched = 2'd0;
      len_bytes    = 2'd0;
      len_value    = 32'd0;
      bytes_taken  = 18'd0;
   endfunction

   function automatic frame_response_type take_link_byte(input logic [7:0] b);
      frame_response_type r;
      logic               claimed;
      int                 i;
      int unsigned        addr;
      r       = '0;
      claimed = 1'b0;
      case (phase)
         PH_SYNC: begin
            if (b == SYNC_WORD[sync_matched]) begin
               if (sync_matched == 2'd3) begin
                  phase        = PH_LEN;
                  sync_matched = 2'd0;
                  len_bytes    = 2'd0;
                  len_value    = 32'd0;
               end else begin
                  sync_matched = sync_matched + 2'd1;
               end
            end else begin
               sync_matched = (b == SYNC_BYTE_0) ? 2'd1 : 2'd0;
            end
         end
         PH_LEN: begin
            len_value = len_value | (32'(b) << (8 * len_bytes));
            if (len_bytes != 2'd3) begin
               len_bytes = len_bytes + 2'd1;
            end else begin
               len_bytes = 2'd0;
               if (len_value == 32'd0 || len_value > 32'(max_len) ||
                   len_value > SLFR_MAX_FRAME_BYTES) begin
                  restart_search();
                  r.status = STS_BAD_LEN;
               end else begin
                  bytes_taken = 18'd0;
                  for (i = 0; i < SLFR_SLOT_COUNT; i++) begin
                     if (!claimed && slot_mode[i] == ST_FREE) begin
                        slot_mode[i] = ST_RECEIVING;
                        fill_slot    = 2'(i);
                        phase        = PH_PAYLOAD;
                        claimed      = 1'b1;
                     end
                  end
                  if (!claimed) begin
                     phase    = PH_DROP;
                     r.status = STS_DROPPING;
                  end
               end
            end
         end
         PH_DROP: begin
            bytes_taken = bytes_taken + 18'd1;
            if (32'(bytes_taken) >= len_value) restart_search();
            r.status = STS_DROPPING;
         end
         default: begin
            addr = fill_slot * SLFR_MAX_FRAME_BYTES + bytes_taken;
            frame_bytes[addr] = b;
            if (bytes_taken + 18'd1 > extent[fill_slot]) extent[fill_slot] = bytes_taken + 18'd1;
            bytes_taken = bytes_taken + 18'd1;
            if (32'(bytes_taken) >= len_value) begin
               for (i = 0; i < SLFR_SLOT_COUNT; i++) begin
                  if (i != fill_slot && slot_mode[i] == ST_READY) begin
                     slot_mode[i] = ST_FREE;
                     slot_len[i]  = 18'd0;
                  end
               end
               seq_counter          = seq_counter + 32'd1;
               slot_len[fill_slot]  = len_value[17:0];
               slot_seq[fill_slot]  = seq_counter;
               slot_mode[fill_slot] = ST_READY;
               r.status       = STS_PUBLISHED;
               r.slot_index   = fill_slot;
               r.frame_len    = len_value[17:0];
               r.frame_seq    = seq_counter;
               frames_published++;
               restart_search();
            end
         end
      endcase
      return r;
   endfunction

   function automatic frame_response_type next_response(input logic [2:0] kind,
                                                        input logic [7:0] b,
                                                        input logic [1:0] rslot,
                                                        input logic [16:0] roff);
      frame_response_type r;
      logic               found;
      int                 best, i;
      int unsigned        addr;
      r     = '0;
      found = 1'b0;
      best  = 0;
      case (kind)
         REQ_BYTE: r = take_link_byte(b);
         REQ_ACQUIRE: begin
            for (i = 0; i < SLFR_SLOT_COUNT; i++) begin
               if (slot_mode[i] == ST_READY && (!found || slot_seq[i] > slot_seq[best])) begin
                  best  = i;
                  found = 1'b1;
               end
            end
            if (found) begin
               slot_mode[best] = ST_READING;
               r.status       = STS_GRANTED;
               r.slot_index   = 2'(best);
               r.frame_len    = slot_len[best];
               r.frame_seq    = slot_seq[best];
            end else begin
               r.status = STS_NONE_RDY;
            end
         end
         REQ_RELEASE: begin
            for (i = 0; i < SLFR_SLOT_COUNT; i++) begin
               if (!found && slot_mode[i] == ST_READING) begin
                  slot_mode[i] = ST_FREE;
                  slot_len[i]  = 18'd0;
                  found        = 1'b1;
               end
            end
         end
         REQ_READ: begin
            addr = rslot * SLFR_MAX_FRAME_BYTES + roff;
            if (rslot < SLFR_SLOT_COUNT && frame_bytes.exists(addr)) r.read_data = frame_bytes[addr];
         end
         REQ_ABORT: begin
            if (phase != PH_SYNC) begin
               if (phase == PH_PAYLOAD && slot_mode[fill_slot] == ST_RECEIVING)
                  slot_mode[fill_slot] = ST_FREE;
               restart_search();
               r.status = STS_ABORTED;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want_v,
                                         input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: rsp_%s mismatch, expected 0x%0h actual 0x%0h",
                  $time, name, want_v, got_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : track_transfers
      frame_response_type want;
      int                 i;
      if (reset) begin
         max_len     = MAX_LEN_RESET;
         restart_search();
         fill_slot   = 2'd0;
         seq_counter = 32'd0;
         extent      = '0;
         for (i = 0; i < SLFR_SLOT_COUNT; i++) begin
            slot_mode[i] = ST_FREE;
            slot_len[i]  = 18'd0;
            slot_seq[i]  = 32'd0;
         end
         awaited.delete();
      end else begin
         if (csr_write_enable) max_len = csr_write_data;
         if (req_valid && req_ready)
            awaited.push_back(next_response(req_type, req_rx_byte, req_read_slot,
                                            req_read_offset));
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               $display("%0t: response with none expected, status %0d data 0x%0h",
                        $time, rsp_status, rsp_read_data);
               error_count++;
            end else begin
               want = awaited.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("slot_index", 32'(want.slot_index), 32'(rsp_slot_index));
               compare_field("frame_len", 32'(want.frame_len), 32'(rsp_frame_len));
               compare_field("frame_seq", want.frame_seq, rsp_frame_seq);
               compare_field("read_data", 32'(want.read_data), 32'(rsp_read_data));
               responses_checked++;
            end
         end
      end
      pending_count  <= awaited.size();
      written_extent <= extent;
   end

endmodule

/* tb/sv/sync_length_frame_receiver_triple_buffer_top_test.sv */
`timescale 1ns / 1ps
// Test bench top for the frame receiver: clock, reset, stimulus and verdict.
module sync_length_frame_receiver_triple_buffer_top_test;
   import slfr_pkg::*;

   localparam logic [3:0][7:0] SYNC_SEQ = {SYNC_BYTE_3, SYNC_BYTE_2, SYNC_BYTE_1, SYNC_BYTE_0};

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [17:0] csr_write_data;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_type;
   logic [7:0]  req_rx_byte;
   logic [1:0]  req_read_slot;
   logic [16:0] req_read_offset;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [1:0]  rsp_slot_index;
   logic [17:0] rsp_frame_len;
   logic [31:0] rsp_frame_seq;
   logic [7:0]  rsp_read_data;

   int unsigned                      errors;
   int unsigned                      pending;
   int unsigned                      checked;
   int unsigned                      published;
   logic [SLFR_SLOT_COUNT-1:0][17:0] extent;

   bit          idling;
   int unsigned items_sent;
   int unsigned calm_left;
   int unsigned settings_used;

   sync_length_frame_receiver_triple_buffer_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_rx_byte      (req_rx_byte),
      .req_read_slot    (req_read_slot),
      .req_read_offset  (req_read_offset),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_frame_len    (rsp_frame_len),
      .rsp_frame_seq    (rsp_frame_seq),
      .rsp_read_data    (rsp_read_data)
   );

   slfr_frame_scoreboard scoreboard (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_rx_byte       (req_rx_byte),
      .req_read_slot     (req_read_slot),
      .req_read_offset   (req_read_offset),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_frame_len     (rsp_frame_len),
      .rsp_frame_seq     (rsp_frame_seq),
      .rsp_read_data     (rsp_read_data),
      .error_count       (errors),
      .pending_count     (pending),
      .responses_checked (checked),
      .frames_published  (published),
      .written_extent    (extent)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Run stopped: time limit reached with %0d responses outstanding", pending);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (idling && $urandom_range(0, 11) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else if (idling && $urandom_range(0, 40) == 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(30, 150)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_item(input logic [2:0] kind, input logic [7:0] b,
                            input logic [1:0] rslot, input logic [16:0] roff);
      if (idling) begin
         if (calm_left != 0) begin
            calm_left--;
         end else if ($urandom_range(0, 63) == 0) begin
            calm_left = $urandom_range(20, 120);
         end else if ($urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_rx_byte     <= b;
      req_read_slot   <= rslot;
      req_read_offset <= roff;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(REQ_BYTE, b, 2'($urandom), 17'($urandom));
   endtask

   task automatic send_op(input logic [2:0] kind);
      send_item(kind, 8'($urandom), 2'($urandom), 17'($urandom));
   endtask

   task automatic send_frame(input logic [31:0] len, input int unsigned body);
      int unsigned i;
      for (i = 0; i < 4; i++) send_byte(SYNC_SEQ[i]);
      for (i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
      for (i = 0; i < body; i++) send_byte(8'($urandom));
   endtask

   task automatic set_max_length(input logic [17:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic random_episode(input logic [17:0] limit);
      logic [31:0] len;
      logic [1:0]  s;
      int unsigned pick, body, cap, i;
      pick = $urandom_range(0, 99);
      cap  = (limit < 12) ? limit : 12;
      if (pick < 55) begin
         repeat ($urandom_range(0, 2))
            send_byte(($urandom_range(0, 2) == 0) ? SYNC_BYTE_0 : 8'($urandom));
         case ($urandom_range(0, 11))
            0:       len = 32'd0;
            1:       len = 32'(limit) + 32'd1;
            2:       len = $urandom;
            3:       len = (limit <= 400) ? 32'(limit) : 32'($urandom_range(1, cap));
            default: len = $urandom_range(1, cap);
         endcase
         body = (len != 0 && len <= 32'(limit)) ? len : 0;
         if (body != 0 && $urandom_range(0, 9) == 0) begin
            send_frame(len, $urandom_range(0, body - 1));
            send_op(REQ_ABORT);
         end else begin
            send_frame(len, body);
         end
      end else if (pick < 85) begin
         case ($urandom_range(0, 3))
            0: send_op(REQ_ACQUIRE);
            1: send_op(REQ_RELEASE);
            default: begin
               s = 2'($urandom_range(0, 3));
               if (s != 2'd3 && extent[s] != 0)
                  send_item(REQ_READ, 8'($urandom), s, 17'($urandom_range(0, extent[s] - 1)));
               else
                  send_item(REQ_READ, 8'($urandom), 2'd3, 17'($urandom));
            end
         endcase
      end else begin
         case ($urandom_range(0, 4))
            0: send_op(REQ_ABORT);
            1: send_op(3'($urandom_range(5, 7)));
            2: send_byte(8'($urandom));
            3: begin
               send_byte(SYNC_BYTE_0);
               send_byte(SYNC_BYTE_1);
               send_byte(8'($urandom));
            end
            default: begin
               for (i = 0; i < 4; i++) send_byte(SYNC_SEQ[i]);
               repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
               send_op(REQ_ABORT);
            end
         endcase
      end
   endtask

   task automatic run_traffic(input logic [17:0] limit, input int unsigned count);
      int unsigned stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) random_episode(limit);
   endtask

   initial begin
      int unsigned k, guard;
      idling           = 1'b1;
      items_sent       = 0;
      calm_left        = 0;
      settings_used    = 0;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 18'd0;
      req_valid        <= 1'b0;
      req_type         <= REQ_BYTE;
      req_rx_byte      <= 8'd0;
      req_read_slot    <= 2'd0;
      req_read_offset  <= 17'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      set_max_length(MAX_LEN_RESET);
      send_op(REQ_ACQUIRE);
      send_op(REQ_RELEASE);
      send_op(REQ_ABORT);
      for (k = 5; k <= 7; k++) send_item(3'(k), 8'hFF, 2'd3, 17'h1FFFF);
      send_item(REQ_READ, 8'h00, 2'd3, 17'h1FFFF);
      send_byte(SYNC_BYTE_0);
      send_frame(32'd0, 0);
      send_frame(32'd1, 1);
      send_op(REQ_ACQUIRE);
      send_item(REQ_READ, 8'h00, 2'd0, 17'd0);

      set_max_length(18'd1);
      run_traffic(18'd1, 480);
      set_max_length(18'd23);
      run_traffic(18'd23, 480);
      set_max_length(18'd300);
      run_traffic(18'd300, 480);

      idling = 1'b0;
      set_max_length(MAX_LEN_RESET);
      send_op(REQ_ABORT);
      repeat (3) send_op(REQ_RELEASE);
      send_frame(32'(SLFR_MAX_FRAME_BYTES) + 32'd1, 0);
      send_frame(32'(SLFR_MAX_FRAME_BYTES), 64);
      send_op(REQ_ABORT);
      send_op(REQ_ACQUIRE);
      for (k = 0; k < SLFR_SLOT_COUNT; k++)
         if (extent[k] != 0)
            send_item(REQ_READ, 8'h00, 2'(k), 17'(extent[k] - 18'd1));
      run_traffic(MAX_LEN_RESET, 100);

      req_valid <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (pending != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);

      $display("Covered %0d requests over %0d length limits (1 to %0d), %0d frames published.",
               items_sent, settings_used, SLFR_MAX_FRAME_BYTES, published);
      $display("%0d responses compared, %0d mismatches, %0d never arrived.",
               checked, errors, pending);
      if (errors == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
sv/slfr_pkg.sv
sv/slfr_ram.sv
sv/slfr_engine.sv
sv/sync_length_frame_receiver_triple_buffer_top.sv
tb/sv/slfr_frame_scoreboard.sv
tb/sv/sync_length_frame_receiver_triple_buffer_top_test.sv
